// ----- sv/vtafc_pkg.sv -----
// Shared types and constants for the vector turn angle block.
package vtafc_pkg;

    // Guard bits below the coordinate LSB inside the rotation datapath.
    localparam int GUARD_BITS = 24;
    // Angle accumulator: unsigned fraction of one turn.
    localparam int ZW = 32;
    localparam int TABLE_SIZE = 32;

    typedef enum logic [1:0] {
        OP_SINGLE = 2'd0,
        OP_PAIR   = 2'd1,
        OP_VERTEX = 2'd2
    } t_op;

    // Sideband that travels next to the data through every stage.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    // atan(2^-i) / (2*pi) * 2^32, rounded.
    localparam logic [ZW-1:0] ATAN_TURNS [TABLE_SIZE] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ----- sv/vtafc_prep.sv -----
// Front end: vector selection / differences, then half-turn pre-rotation and scaling.
module vtafc_prep #(
    parameter int COORD_WIDTH = 16,
    localparam int W = COORD_WIDTH + vtafc_pkg::GUARD_BITS + 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  vtafc_pkg::t_ctl               i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_third_x,
    input  logic signed [COORD_WIDTH-1:0] i_third_y,
    output vtafc_pkg::t_ctl               o_ctl,
    output logic signed [W-1:0]           o_x [2],
    output logic signed [W-1:0]           o_y [2],
    output logic [vtafc_pkg::ZW-1:0]      o_z [2],
    output logic                          o_zero [2]
);

    localparam int W1 = COORD_WIDTH + 1;   // differences
    localparam int W2 = COORD_WIDTH + 2;   // negated differences

    // Stage 1: pick the two vectors (lane 0 is subtracted from lane 1).
    vtafc_pkg::t_ctl        r_ctl1;
    logic signed [W1-1:0]   r_vx [2];
    logic signed [W1-1:0]   r_vy [2];
    logic signed [W1-1:0]   n_vx [2];
    logic signed [W1-1:0]   n_vy [2];

    always_comb begin
        if (i_ctl.op == vtafc_pkg::OP_VERTEX) begin
            n_vx[0] = W1'(i_second_x) - W1'(i_first_x);
            n_vy[0] = W1'(i_second_y) - W1'(i_first_y);
            n_vx[1] = W1'(i_third_x) - W1'(i_second_x);
            n_vy[1] = W1'(i_third_y) - W1'(i_second_y);
        end else begin
            n_vx[0] = W1'(i_first_x);
            n_vy[0] = W1'(i_first_y);
            n_vx[1] = W1'(i_second_x);
            n_vy[1] = W1'(i_second_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
        end
    end

    // Stage 2: fold left half-plane by half a turn, flag zero vectors, scale.
    vtafc_pkg::t_ctl r_ctl2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl2 <= r_ctl1;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic                  neg;
        logic signed [W2-1:0]  fx;
        logic signed [W2-1:0]  fy;
        logic signed [W-1:0]   r_x;
        logic signed [W-1:0]   r_y;
        logic [vtafc_pkg::ZW-1:0] r_z;
        logic                  r_zero;

        assign neg = r_vx[l][W1-1];
        assign fx  = neg ? -W2'(r_vx[l]) : W2'(r_vx[l]);
        assign fy  = neg ? -W2'(r_vy[l]) : W2'(r_vy[l]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= W'(fx) <<< vtafc_pkg::GUARD_BITS;
                r_y    <= W'(fy) <<< vtafc_pkg::GUARD_BITS;
                r_z    <= {neg, {(vtafc_pkg::ZW-1){1'b0}}};
                r_zero <= (r_vx[l] == '0) && (r_vy[l] == '0);
            end
        end

        assign o_x[l]    = r_x;
        assign o_y[l]    = r_y;
        assign o_z[l]    = r_z;
        assign o_zero[l] = r_zero;
    end

    assign o_ctl = r_ctl2;

endmodule

// ----- sv/vtafc_cordic.sv -----
// Two-lane vectoring CORDIC, one register stage per iteration.
module vtafc_cordic #(
    parameter int COORD_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16,
    localparam int W = COORD_WIDTH + vtafc_pkg::GUARD_BITS + 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  vtafc_pkg::t_ctl           i_ctl,
    input  logic signed [W-1:0]       i_x [2],
    input  logic signed [W-1:0]       i_y [2],
    input  logic [vtafc_pkg::ZW-1:0]  i_z [2],
    input  logic                      i_zero [2],
    output vtafc_pkg::t_ctl           o_ctl,
    output logic [vtafc_pkg::ZW-1:0]  o_z [2]
);

    localparam int ZW = vtafc_pkg::ZW;

    // stg_*[g] is the input of iteration g; stg_*[CORDIC_STEPS] the result.
    vtafc_pkg::t_ctl    stg_ctl  [CORDIC_STEPS+1];
    logic signed [W-1:0] stg_x   [CORDIC_STEPS+1][2];
    logic signed [W-1:0] stg_y   [CORDIC_STEPS+1][2];
    logic [ZW-1:0]       stg_z   [CORDIC_STEPS+1][2];
    logic                stg_zero[CORDIC_STEPS+1][2];

    vtafc_pkg::t_ctl    r_ctl  [CORDIC_STEPS];
    logic signed [W-1:0] r_x   [CORDIC_STEPS][2];
    logic signed [W-1:0] r_y   [CORDIC_STEPS][2];
    logic [ZW-1:0]       r_z   [CORDIC_STEPS][2];
    logic                r_zero[CORDIC_STEPS][2];

    assign stg_ctl[0] = i_ctl;

    for (genvar l = 0; l < 2; l++) begin : g_in
        assign stg_x[0][l]    = i_x[l];
        assign stg_y[0][l]    = i_y[l];
        assign stg_z[0][l]    = i_z[l];
        assign stg_zero[0][l] = i_zero[l];
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g] <= '0;
            end else if (i_en) begin
                r_ctl[g] <= stg_ctl[g];
            end
        end
        assign stg_ctl[g+1] = r_ctl[g];

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [W-1:0] n_x;
            logic signed [W-1:0] n_y;
            logic [ZW-1:0]       n_z;

            // Drive y toward zero; the rotation sense follows the sign of y.
            always_comb begin
                if (!stg_y[g][l][W-1]) begin
                    n_x = stg_x[g][l] + (stg_y[g][l] >>> g);
                    n_y = stg_y[g][l] - (stg_x[g][l] >>> g);
                    n_z = stg_z[g][l] + vtafc_pkg::ATAN_TURNS[g];
                end else begin
                    n_x = stg_x[g][l] - (stg_y[g][l] >>> g);
                    n_y = stg_y[g][l] + (stg_x[g][l] >>> g);
                    n_z = stg_z[g][l] - vtafc_pkg::ATAN_TURNS[g];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g][l]    <= n_x;
                    r_y[g][l]    <= n_y;
                    r_z[g][l]    <= n_z;
                    r_zero[g][l] <= stg_zero[g][l];
                end
            end

            assign stg_x[g+1][l]    = r_x[g][l];
            assign stg_y[g+1][l]    = r_y[g][l];
            assign stg_z[g+1][l]    = r_z[g][l];
            assign stg_zero[g+1][l] = r_zero[g][l];
        end
    end

    assign o_ctl = stg_ctl[CORDIC_STEPS];

    // A zero vector has angle zero regardless of what the iterations did.
    for (genvar l = 0; l < 2; l++) begin : g_out
        assign o_z[l] = stg_zero[CORDIC_STEPS][l] ? '0 : stg_z[CORDIC_STEPS][l];
    end

endmodule

// ----- sv/vtafc_post.sv -----
// Back end: angle difference per opcode, then rounding to the output width.
module vtafc_post #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  vtafc_pkg::t_ctl           i_ctl,
    input  logic [vtafc_pkg::ZW-1:0]  i_z [2],
    output logic                      o_valid,
    output logic [ANGLE_WIDTH-1:0]    o_angle
);

    localparam int ZW = vtafc_pkg::ZW;
    localparam int SH = ZW - ANGLE_WIDTH;

    logic          r_dvalid;
    logic [ZW-1:0] r_dz;
    logic [ZW-1:0] n_dz;

    always_comb begin
        unique case (i_ctl.op)
            vtafc_pkg::OP_SINGLE: n_dz = i_z[0];
            vtafc_pkg::OP_PAIR,
            vtafc_pkg::OP_VERTEX: n_dz = i_z[1] - i_z[0];
            default:              n_dz = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
        end else if (i_en) begin
            r_dvalid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dz <= n_dz;
        end
    end

    // Round half up; carry out of the top is the wrap at one full turn.
    logic [ANGLE_WIDTH-1:0] n_angle;

    if (SH > 0) begin : g_round
        logic [ZW-1:0] sum;
        assign sum     = r_dz + (ZW'(1) << (SH - 1));
        assign n_angle = sum[ZW-1:SH];
    end else begin : g_full
        assign n_angle = r_dz;
    end

    logic                   r_valid;
    logic [ANGLE_WIDTH-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_dvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_valid;
    assign o_angle = r_angle;

endmodule

// ----- sv/vector_turn_angle_full_circle.sv -----
// Top level: pipelined CORDIC angle of a vector, between two vectors, or at a vertex.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_op, i_first_*, i_second_*,
//          |           |                            | i_third_*
//  out     | source    | o_out_valid / i_out_stall  | o_angle
//
//  Throughput is one transaction per cycle while the output is not stalled; the stages
//  are two front-end stages, one stage per CORDIC iteration, difference and rounding.
//  Each CORDIC iteration is one 45-bit add/subtract per coordinate, which sets
//  the stage depth. Reset (i_rst_n low, synchronous) clears every valid bit.
//  The whole pipeline advances together: it holds only while a result sits in
//  the output register and the consumer stalls, and then o_in_stall is raised.
module vector_turn_angle_full_circle #(
    parameter int COORD_WIDTH  = 16,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_third_x,
    input  logic signed [COORD_WIDTH-1:0] i_third_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ANGLE_WIDTH-1:0]        o_angle
);

    localparam int W  = COORD_WIDTH + vtafc_pkg::GUARD_BITS + 5;
    localparam int ZW = vtafc_pkg::ZW;

    // Pipeline advance: bubbles are not squeezed out, so a stalled output
    // freezes every stage and nothing is lost or repeated.
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    vtafc_pkg::t_ctl in_ctl;
    assign in_ctl.valid = i_in_valid;
    assign in_ctl.op    = vtafc_pkg::t_op'(i_op);

    // Front end -> CORDIC
    vtafc_pkg::t_ctl     prep_ctl;
    logic signed [W-1:0] prep_x [2];
    logic signed [W-1:0] prep_y [2];
    logic [ZW-1:0]       prep_z [2];
    logic                prep_zero [2];

    vtafc_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctl      (in_ctl),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .o_ctl      (prep_ctl),
        .o_x        (prep_x),
        .o_y        (prep_y),
        .o_z        (prep_z),
        .o_zero     (prep_zero)
    );

    // CORDIC -> back end; lane 0 is the reference direction
    vtafc_pkg::t_ctl cor_ctl;
    logic [ZW-1:0]   cor_z [2];

    vtafc_cordic #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (prep_ctl),
        .i_x     (prep_x),
        .i_y     (prep_y),
        .i_z     (prep_z),
        .i_zero  (prep_zero),
        .o_ctl   (cor_ctl),
        .o_z     (cor_z)
    );

    // Output register lives in the back end.
    vtafc_post #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (cor_ctl),
        .i_z     (cor_z),
        .o_valid (o_out_valid),
        .o_angle (o_angle)
    );

endmodule

// ----- sv/vtafc_check.sv -----
// Port-level checker for the vector turn angle block, with its bind.
module vtafc_check #(
    parameter int ANGLE_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [ANGLE_WIDTH-1:0] o_angle
);

    // Input is held back exactly when a finished result cannot leave.
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to a blocked output");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_angle)))
        else $error("stalled result changed or dropped");

    // While the input is stalled with a transaction offered, the output result is not emptied.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && i_in_valid) |=> o_out_valid)
        else $error("output emptied while input was stalled");

endmodule

bind vector_turn_angle_full_circle vtafc_check #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_vtafc_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_angle     (o_angle)
);

// ----- tb/tb_vector_turn_angle_full_circle.sv -----
`timescale 1ns / 1ps
// Testbench for vector_turn_angle_full_circle: directed table, then random transactions.
module tb_vector_turn_angle_full_circle;

    localparam int COORD_W      = 16;
    localparam int ANGLE_W      = 16;
    localparam int CORDIC_STEPS = 16;
    // Fraction bits added below the coordinate LSB before rotating.
    localparam int SCALE_BITS   = 24;
    localparam int ANGLE_SHIFT  = 32 - ANGLE_W;
    localparam int LATENCY      = CORDIC_STEPS + 4;
    // Op code the block has no enum member for; it must give angle 0.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 900;
    // Long output hold-off, so the pipeline fills and stalls its input.
    localparam int HOLD_OFF     = 400;
    localparam int HOLD_AFTER   = 300;
    // Cycles with no transaction on either channel before giving up.
    localparam int STALL_LIMIT  = 5000;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        logic [1:0]                  op;
        logic signed [COORD_W-1:0]   ax, ay, bx, by, cx, cy;
    } t_vertex_item;

    // One directed row; angle is only used where known is set.
    typedef struct {
        t_vertex_item                it;
        logic                        known;
        logic [ANGLE_W-1:0]          angle;
    } t_directed_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [1:0]                    i_op;
    logic signed [COORD_W-1:0]     i_first_x, i_first_y;
    logic signed [COORD_W-1:0]     i_second_x, i_second_y;
    logic signed [COORD_W-1:0]     i_third_x, i_third_y;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [ANGLE_W-1:0]            o_angle;

    logic [ANGLE_W-1:0]            pending_angles [$];
    t_directed_row                 directed_rows [$];
    logic [ANGLE_W-1:0]            oldest_angle;
    int                            angle_errors = 0;
    int                            angles_seen  = 0;
    int                            idle_cycles  = 0;
    int                            burst_left   = 0;

    always #5 i_clk = ~i_clk;

    vector_turn_angle_full_circle #(
        .COORD_WIDTH  (COORD_W),
        .ANGLE_WIDTH  (ANGLE_W),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .i_third_x   (i_third_x),
        .i_third_y   (i_third_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_angle     (o_angle)
    );

    // Direction of (x, y) as a 32-bit fraction of a turn, vectoring CORDIC.
    function automatic logic [31:0] turn_fraction(longint x, longint y);
        logic [31:0] z;
        longint      dx;
        longint      dy;
        z = '0;
        if (x == 0 && y == 0) return '0;
        // Left half plane: rotate by half a turn first.
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        x = x <<< SCALE_BITS;
        y = y <<< SCALE_BITS;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    // Expected output angle: difference mod one turn, rounded half up, wrapped.
    function automatic logic [ANGLE_W-1:0] predict_angle(t_vertex_item it);
        logic [31:0] z;
        logic [32:0] r;
        case (it.op)
            vtafc_pkg::OP_SINGLE: z = turn_fraction(it.ax, it.ay);
            vtafc_pkg::OP_PAIR:   z = turn_fraction(it.bx, it.by)
                                    - turn_fraction(it.ax, it.ay);
            vtafc_pkg::OP_VERTEX: z = turn_fraction(longint'(it.cx) - longint'(it.bx),
                                                    longint'(it.cy) - longint'(it.by))
                                    - turn_fraction(longint'(it.bx) - longint'(it.ax),
                                                    longint'(it.by) - longint'(it.ay));
            default:              return '0;
        endcase
        r = {1'b0, z} + (33'd1 << (ANGLE_SHIFT - 1));
        return r[ANGLE_SHIFT +: ANGLE_W];
    endfunction

    function automatic t_directed_row dir_row(logic [1:0] op, int ax, int ay, int bx, int by,
                                              int cx, int cy, logic known,
                                              logic [ANGLE_W-1:0] angle);
        t_directed_row row;
        row.it.op = op;
        row.it.ax = 16'(ax);
        row.it.ay = 16'(ay);
        row.it.bx = 16'(bx);
        row.it.by = 16'(by);
        row.it.cx = 16'(cx);
        row.it.cy = 16'(cy);
        row.known = known;
        row.angle = angle;
        return row;
    endfunction

    // Mostly full-range values, with a share of small values, extremes and zero.
    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 16)) - 16'd8;
            1: case ($urandom_range(0, 4))
                   0: return 16'h7FFF;
                   1: return 16'h8000;
                   2: return 16'h0000;
                   3: return 16'h0001;
                   default: return 16'hFFFF;
               endcase
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_vertex_item random_item();
        t_vertex_item it;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.op = vtafc_pkg::OP_SINGLE;
        else if (pick < 60) it.op = vtafc_pkg::OP_PAIR;
        else if (pick < 93) it.op = vtafc_pkg::OP_VERTEX;
        else                it.op = OP_UNUSED;
        it.ax = rand_coord();
        it.ay = rand_coord();
        it.bx = rand_coord();
        it.by = rand_coord();
        it.cx = rand_coord();
        it.cy = rand_coord();
        // Now and then a degenerate shape: repeated point or equal spacing.
        case ($urandom_range(0, 19))
            0: begin
                it.bx = it.ax;
                it.by = it.ay;
            end
            1: begin
                it.cx = it.bx + (it.bx - it.ax);
                it.cy = it.by + (it.by - it.ay);
            end
            2: begin
                it.cx = it.bx;
                it.cy = it.by;
            end
            default: ;
        endcase
        return it;
    endfunction

    // Hold one transaction on the input until accepted, then log its expectation.
    task automatic offer_item(t_vertex_item it, logic [ANGLE_W-1:0] want);
        i_in_valid <= 1'b1;
        i_op       <= it.op;
        i_first_x  <= it.ax;
        i_first_y  <= it.ay;
        i_second_x <= it.bx;
        i_second_y <= it.by;
        i_third_x  <= it.cx;
        i_third_y  <= it.cy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_angles.push_back(want);
    endtask

    // Bursts of random length, random gaps between them (gap may be zero).
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Sender goes quiet until every pending angle has come back.
    task automatic wait_for_empty();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_angles.size() != 0);
    endtask

    initial begin : stimulus
        t_vertex_item       it;
        logic [ANGLE_W-1:0] want;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= vtafc_pkg::OP_SINGLE;
        i_first_x  <= '0;
        i_first_y  <= '0;
        i_second_x <= '0;
        i_second_y <= '0;
        i_third_x  <= '0;
        i_third_y  <= '0;

        // Zero vector, axes, corners, near-full-turn wrap, unused fields.
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 0, 0, 0, 0, 0, 0, 1'b1, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 32767, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, -32768, 0, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 0, 32767, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 0, -32768, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, -32768, -32768, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 32767, -1, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, -1, -32768, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, -32768, 32767, 0, 0, 0, 0,
                                        1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_SINGLE, 1000, 2000, -7, -8, 99, -99,
                                        1'b0, '0));
        // Pair: both zero, identical vectors, quarter turns, opposite, one zero.
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 0, 0, 0, 0, 0, 0, 1'b1, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 12345, -321, 12345, -321, 0, 0,
                                        1'b1, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 1, 0, 0, 1, 0, 0, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 0, 1, 1, 0, -5, 5, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 32767, 32767, -32768, -32768,
                                        0, 0, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_PAIR, 0, 0, -5, 7, 0, 0, 1'b0, '0));
        // Vertex: coincident points, equal spacing, 17-bit differences.
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, -32768, 32767, -32768, 32767,
                                        -32768, 32767, 1'b1, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, -100, 50, 0, 0, 100, -50,
                                        1'b1, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, -32768, -32768, 0, 0,
                                        32767, 32767, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, -32768, 0, 32767, 0,
                                        -32768, 0, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, 32767, -32768, -32768, 32767,
                                        32767, -32768, 1'b0, '0));
        directed_rows.push_back(dir_row(vtafc_pkg::OP_VERTEX, 0, 0, 3, 4, 3, 9, 1'b0, '0));
        // Unused op code always gives 0.
        directed_rows.push_back(dir_row(OP_UNUSED, 32767, 32767, 32767, 32767,
                                        32767, 32767, 1'b1, '0));
        directed_rows.push_back(dir_row(OP_UNUSED, -32768, -32768, -32768, -32768,
                                        -32768, -32768, 1'b1, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            want = directed_rows[k].known ? directed_rows[k].angle
                                          : predict_angle(directed_rows[k].it);
            offer_item(directed_rows[k].it, want);
            pace_sender();
        end
        wait_for_empty();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // One full drain two thirds of the way through the random part.
            if (n == 2 * RANDOM_ITEMS / 3) wait_for_empty();
            it = random_item();
            offer_item(it, predict_angle(it));
            pace_sender();
        end

        wait_for_empty();
        // Let anything spurious still in flight show up at the output.
        repeat (LATENCY + 8) @(posedge i_clk);
        if (angle_errors == 0 && pending_angles.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Output stall pattern: free stretches, solid stall runs, random per-cycle stalls,
    // plus one long hold-off once enough results have come through.
    initial begin : out_stall_pattern
        logic hold_done;
        int   pct;
        hold_done = 1'b0;
        forever begin
            if (!hold_done && angles_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            case ($urandom_range(0, 3))
                0: begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(20, 120)) @(posedge i_clk);
                end
                1: begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end
                default: begin
                    pct = $urandom_range(10, 80);
                    repeat ($urandom_range(10, 60)) begin
                        i_out_stall <= ($urandom_range(0, 99) < pct);
                        @(posedge i_clk);
                    end
                end
            endcase
        end
    end

    // Each output transaction is matched against the oldest pending angle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            angles_seen++;
            if (pending_angles.size() == 0) begin
                angle_errors++;
                if (angle_errors <= 10)
                    $display("result %0d arrived with nothing pending: angle %h",
                             angles_seen, o_angle);
            end else begin
                oldest_angle = pending_angles.pop_front();
                if (o_angle !== oldest_angle) begin
                    angle_errors++;
                    if (angle_errors <= 10)
                        $display("angle mismatch on result %0d: expected %h, got %h",
                                 angles_seen, oldest_angle, o_angle);
                end
            end
        end
    end

    // Watchdog: no transaction on either channel for too long means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
